FILE: hdl/wfba_pkg.sv
// Package for the worst-fit block allocator: sizes, status and step codes,
// control word layout and the microcode table. No dependencies.
`timescale 1ns / 1ps

package wfba_pkg;

  localparam int NUM_BLOCKS   = 64;
  localparam int SIZE_BITS    = 16;
  localparam int IDX_BITS     = $clog2(NUM_BLOCKS);
  localparam int CNT_BITS     = $clog2(NUM_BLOCKS + 1);
  localparam int AMOUNT_BITS  = 16;
  localparam int CMP_BITS     = (SIZE_BITS > AMOUNT_BITS) ? SIZE_BITS : AMOUNT_BITS;
  localparam int BCOUNT_BITS  = 7;
  localparam int INDEX_BITS   = 6;
  localparam int REMAIN_BITS  = 16;
  localparam logic [BCOUNT_BITS-1:0] BCOUNT_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_LOADED     = 2'd0,
    ST_PLACED     = 2'd1,
    ST_NOT_PLACED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_FETCH  = 3'd0,
    S_DECODE = 3'd1,
    S_LOAD   = 3'd2,
    S_INIT   = 3'd3,
    S_SCAN   = 3'd4,
    S_DRAIN  = 3'd5,
    S_WB     = 3'd6,
    S_EMIT   = 3'd7
  } step_t;

  typedef enum logic [2:0] {
    C_NONE       = 3'd0,
    C_NO_ACCEPT  = 3'd1,
    C_IS_LOAD    = 3'd2,
    C_COUNT_ZERO = 3'd3,
    C_SCAN_MORE  = 3'd4,
    C_OUT_BUSY   = 3'd5
  } cond_t;

  typedef struct packed {
    step_t nxt;
    cond_t cond;
    step_t target;
    logic  take;
    logic  load_wr;
    logic  scan_init;
    logic  scan_issue;
    logic  write_back;
    logic  emit;
  } uop_t;

  typedef struct packed {
    logic no_accept;
    logic is_load;
    logic count_zero;
    logic scan_more;
    logic out_busy;
  } dp_flags_t;

  function automatic uop_t ucode_rom(step_t s);
    uop_t u;
    u = '{nxt: S_FETCH, cond: C_NONE, target: S_FETCH, take: 1'b0, load_wr: 1'b0,
          scan_init: 1'b0, scan_issue: 1'b0, write_back: 1'b0, emit: 1'b0};
    case (s)
      S_FETCH: begin
        u.take = 1'b1; u.cond = C_NO_ACCEPT; u.target = S_FETCH; u.nxt = S_DECODE;
      end
      S_DECODE: begin
        u.cond = C_IS_LOAD; u.target = S_LOAD; u.nxt = S_INIT;
      end
      S_LOAD: begin
        u.load_wr = 1'b1; u.nxt = S_EMIT;
      end
      S_INIT: begin
        u.scan_init = 1'b1; u.cond = C_COUNT_ZERO; u.target = S_EMIT; u.nxt = S_SCAN;
      end
      S_SCAN: begin
        u.scan_issue = 1'b1; u.cond = C_SCAN_MORE; u.target = S_SCAN; u.nxt = S_DRAIN;
      end
      S_DRAIN: begin
        u.nxt = S_WB;
      end
      S_WB: begin
        u.write_back = 1'b1; u.nxt = S_EMIT;
      end
      S_EMIT: begin
        u.emit = 1'b1; u.cond = C_OUT_BUSY; u.target = S_EMIT; u.nxt = S_FETCH;
      end
      default: begin
        u.nxt = S_FETCH;
      end
    endcase
    return u;
  endfunction

endpackage

FILE: hdl/worst_fit_block_allocator.sv
// Worst-fit block allocator, top level: microcode sequencer plus datapath.
// Depends on wfba_pkg, wfba_seq, wfba_dp.
//
// Input channel (in_valid / in_stall) carries one item per transfer:
// command 0 loads amount into table entry load_index, command 1 asks for
// amount units from the largest free entry among the first block_count.
// Output channel (out_valid / out_stall) returns one result per item:
// status, chosen_block, remaining_size and batch_done (echo of last_request).
// block_count is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while idle, the block does not enforce it. A load steps
// through decode, load and emit; an allocate through decode, init, one
// scan step per entry (one read each on the single RAM read port), drain,
// write-back and emit, or init to emit at zero count. A new item is taken
// at fetch, in the cycle after the result is placed in the output register.
// When the receiver stalls, the result holds in the output register; a
// following item may still be taken and worked, and waits at its emit step.
// Reset (rst, synchronous) returns the sequencer to fetch, empties the output
// and sets block_count to 64; table entries are undefined until loaded.
`timescale 1ns / 1ps

module worst_fit_block_allocator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [wfba_pkg::BCOUNT_BITS-1:0] cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             command,
  input  logic [wfba_pkg::INDEX_BITS-1:0]  load_index,
  input  logic [wfba_pkg::AMOUNT_BITS-1:0] amount,
  input  logic                             last_request,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic [wfba_pkg::INDEX_BITS-1:0]  chosen_block,
  output logic [wfba_pkg::REMAIN_BITS-1:0] remaining_size,
  output logic                             batch_done
);

  wfba_pkg::uop_t      uop;
  wfba_pkg::dp_flags_t flags;

  assign in_stall = !uop.take;

  wfba_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .uop   (uop)
  );

  wfba_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .uop            (uop),
    .flags          (flags),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .command        (command),
    .load_index     (load_index),
    .amount         (amount),
    .last_request   (last_request),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .chosen_block   (chosen_block),
    .remaining_size (remaining_size),
    .batch_done     (batch_done)
  );

  a_take_once: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while one is in work");

  a_loaded_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == wfba_pkg::ST_LOADED) |-> (chosen_block == '0 && remaining_size == '0))
    else $error("load result carries a block or size");

  a_unplaced_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == wfba_pkg::ST_NOT_PLACED)
      |-> (chosen_block == '0 && remaining_size == '0))
    else $error("unplaced result carries a block or size");

endmodule

FILE: hdl/wfba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wfba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/wfba_seq.sv
// Microcode sequencer: step counter, control word fetch from the table in
// wfba_pkg and conditional jumps on datapath flags. Depends on wfba_pkg.
`timescale 1ns / 1ps

module wfba_seq (
  input  logic              clk,
  input  logic              rst,
  input  wfba_pkg::dp_flags_t flags,
  output wfba_pkg::uop_t    uop
);

  wfba_pkg::step_t step;
  wfba_pkg::step_t step_next;
  logic            jump;

  assign uop = wfba_pkg::ucode_rom(step);

  always_comb begin
    case (uop.cond)
      wfba_pkg::C_NONE:       jump = 1'b0;
      wfba_pkg::C_NO_ACCEPT:  jump = flags.no_accept;
      wfba_pkg::C_IS_LOAD:    jump = flags.is_load;
      wfba_pkg::C_COUNT_ZERO: jump = flags.count_zero;
      wfba_pkg::C_SCAN_MORE:  jump = flags.scan_more;
      wfba_pkg::C_OUT_BUSY:   jump = flags.out_busy;
      default:                jump = 1'b0;
    endcase
    step_next = jump ? uop.target : uop.nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= wfba_pkg::S_FETCH;
    end else begin
      step <= step_next;
    end
  end

endmodule

FILE: hdl/wfba_dp.sv
// Datapath: item latch, block count register, free size table, scan with two
// comparators, write-back, output register. Depends on wfba_pkg, wfba_ram.
`timescale 1ns / 1ps

module wfba_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  wfba_pkg::uop_t                       uop,
  output wfba_pkg::dp_flags_t                  flags,
  input  logic                                 cfg_wr_en,
  input  logic [wfba_pkg::BCOUNT_BITS-1:0]     cfg_wr_data,
  input  logic                                 in_valid,
  input  logic                                 command,
  input  logic [wfba_pkg::INDEX_BITS-1:0]      load_index,
  input  logic [wfba_pkg::AMOUNT_BITS-1:0]     amount,
  input  logic                                 last_request,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           status,
  output logic [wfba_pkg::INDEX_BITS-1:0]      chosen_block,
  output logic [wfba_pkg::REMAIN_BITS-1:0]     remaining_size,
  output logic                                 batch_done
);

  logic [wfba_pkg::BCOUNT_BITS-1:0] block_count;
  logic [wfba_pkg::CNT_BITS-1:0]    sat_count;
  logic [wfba_pkg::CNT_BITS-1:0]    count;
  logic                             cmd;
  logic [wfba_pkg::INDEX_BITS-1:0]  idx;
  logic [wfba_pkg::AMOUNT_BITS-1:0] amt;
  logic                             last;
  logic [wfba_pkg::IDX_BITS-1:0]    scan_idx;
  logic                             pend;
  logic [wfba_pkg::IDX_BITS-1:0]    pend_idx;
  logic                             found;
  logic [wfba_pkg::IDX_BITS-1:0]    best_idx;
  logic [wfba_pkg::SIZE_BITS-1:0]   best_val;
  logic [wfba_pkg::SIZE_BITS-1:0]   rd_data;
  logic [wfba_pkg::SIZE_BITS-1:0]   left;
  logic                             idx_in_range;
  logic                             fits;
  logic                             better;
  logic                             out_busy;
  logic                             emit_fire;
  logic                             ram_wr_en;
  logic [wfba_pkg::IDX_BITS-1:0]    ram_wr_addr;
  logic [wfba_pkg::SIZE_BITS-1:0]   ram_wr_data;
  wfba_pkg::status_t                res_status;
  logic [wfba_pkg::IDX_BITS-1:0]    res_chosen;
  logic [wfba_pkg::SIZE_BITS-1:0]   res_left;

  always_comb begin
    if (32'(block_count) > wfba_pkg::NUM_BLOCKS) begin
      sat_count = wfba_pkg::CNT_BITS'(wfba_pkg::NUM_BLOCKS);
    end else begin
      sat_count = wfba_pkg::CNT_BITS'(block_count);
    end
  end

  assign idx_in_range = 32'(idx) < wfba_pkg::NUM_BLOCKS;
  assign fits   = wfba_pkg::CMP_BITS'(rd_data) >= wfba_pkg::CMP_BITS'(amt);
  assign better = !found || (best_val < rd_data);
  assign left   = wfba_pkg::SIZE_BITS'(wfba_pkg::CMP_BITS'(best_val)
                                       - wfba_pkg::CMP_BITS'(amt));
  assign out_busy  = out_valid && out_stall;
  assign emit_fire = uop.emit && !out_busy;

  assign flags.no_accept  = !in_valid;
  assign flags.is_load    = !cmd;
  assign flags.count_zero = sat_count == '0;
  assign flags.scan_more  = wfba_pkg::CNT_BITS'(wfba_pkg::CNT_BITS'(scan_idx)
                                                + wfba_pkg::CNT_BITS'(1)) != count;
  assign flags.out_busy   = out_busy;

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = wfba_pkg::IDX_BITS'(idx);
    ram_wr_data = wfba_pkg::SIZE_BITS'(amt);
    if (uop.load_wr) begin
      ram_wr_en = idx_in_range;
    end else if (uop.write_back) begin
      ram_wr_en   = found;
      ram_wr_addr = best_idx;
      ram_wr_data = left;
    end
  end

  wfba_ram #(
    .WIDTH(wfba_pkg::SIZE_BITS),
    .DEPTH(wfba_pkg::NUM_BLOCKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (uop.scan_issue),
    .rd_addr (scan_idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= wfba_pkg::BCOUNT_RESET;
      pend        <= 1'b0;
      found       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        block_count <= cfg_wr_data;
      end
      pend <= uop.scan_issue;
      if (uop.scan_init) begin
        found <= 1'b0;
      end else if (pend && fits && better) begin
        found <= 1'b1;
      end
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (uop.take && in_valid) begin
      cmd  <= command;
      idx  <= load_index;
      amt  <= amount;
      last <= last_request;
    end
    if (uop.scan_init) begin
      count    <= sat_count;
      scan_idx <= '0;
    end else if (uop.scan_issue) begin
      scan_idx <= scan_idx + 1'b1;
    end
    pend_idx <= scan_idx;
    if (pend && fits && better) begin
      best_idx <= pend_idx;
      best_val <= rd_data;
    end
    if (uop.load_wr) begin
      res_status <= wfba_pkg::ST_LOADED;
      res_chosen <= '0;
      res_left   <= '0;
    end else if (uop.scan_init) begin
      res_status <= wfba_pkg::ST_NOT_PLACED;
      res_chosen <= '0;
      res_left   <= '0;
    end else if (uop.write_back && found) begin
      res_status <= wfba_pkg::ST_PLACED;
      res_chosen <= best_idx;
      res_left   <= left;
    end
    if (emit_fire) begin
      status         <= res_status;
      chosen_block   <= wfba_pkg::INDEX_BITS'(res_chosen);
      remaining_size <= wfba_pkg::REMAIN_BITS'(res_left);
      batch_done     <= last;
    end
  end

  a_found_needs_fit: assert property (@(posedge clk) disable iff (rst)
    (pend && fits && better) |=> found)
    else $error("best entry not marked found");

  a_scan_pend: assert property (@(posedge clk) disable iff (rst)
    uop.scan_issue |=> pend)
    else $error("table read not followed by compare");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit_fire |=> out_valid)
    else $error("result lost at output register");

endmodule
